FILE: rtl/mouse_nibble_handshake_port_defines.svh
// Assertion helpers used by the mouse port core (mnhp_core)
`ifndef MOUSE_NIBBLE_HANDSHAKE_PORT_DEFINES_SVH
`define MOUSE_NIBBLE_HANDSHAKE_PORT_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define MNHP_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle
`define MNHP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: rtl/mnhp_pkg.sv
package mnhp_pkg;

   // Countdown width default
   localparam int unsigned DELAY_BITS_DEF = 8;

   // Item kinds
   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_MAX_SPEED       = 2'd0;
   localparam logic [1:0] CSR_HANDSHAKE_DELAY = 2'd1;
   localparam logic [1:0] CSR_DATA_DELAY      = 2'd2;

   // Configuration reset values
   localparam logic [7:0] MAX_SPEED_RST       = 8'd255;
   localparam logic [7:0] HANDSHAKE_DELAY_RST = 8'd28;
   localparam logic [7:0] DATA_DELAY_RST      = 8'd20;

   // Frame header nibbles and index bounds
   localparam logic [3:0] HDR_NIB0   = 4'h0;
   localparam logic [3:0] HDR_NIB1   = 4'hB;
   localparam logic [3:0] HDR_NIB2   = 4'hF;
   localparam logic [3:0] HDR_NIB3   = 4'hF;
   localparam logic [3:0] IDX_FIRST  = 4'd1;
   localparam logic [3:0] IDX_LAST   = 4'd9;

   typedef struct packed {
      logic               func;
      logic               write_clock;
      logic               write_select;
      logic signed [15:0] move_x;
      logic signed [15:0] move_y;
      logic               button_left;
      logic               button_right;
      logic               button_middle;
      logic               button_start;
   } req_type;

   typedef struct packed {
      logic [3:0] port_nibble;
      logic       ack_level;
   } rsp_type;

   // Variable part of the frame, nibbles four to nine
   typedef struct packed {
      logic [3:0] sign_nib;
      logic [3:0] button_nib;
      logic [3:0] x_hi;
      logic [3:0] x_lo;
      logic [3:0] y_hi;
      logic [3:0] y_lo;
   } frame_type;

endpackage

FILE: rtl/mouse_nibble_handshake_port.sv
// Mouse port, device side. Each word on the req_ channel is a timer tick
// (func low) or a host port write (func high) carrying the clock and select
// levels plus the current motion and buttons. Every word returns exactly one
// rsp_ word: the nibble driven on the data pins and the ack line level, both
// as they stand after that word. Configuration (max speed, handshake delay,
// data delay) is written through csr_we / csr_index / csr_wdata; the user must
// write it only while idle, which the block does not enforce. The result is
// registered on acceptance. Throughput: one word per cycle; req_ready stays
// high while the result register is empty or being taken, so the next word
// enters in the same cycle that the previous result leaves. The frame clamp and
// countdown update sit between the input handshake and the result register.
// When the receiver stalls, the result is held and req_ready drops until it is
// taken. Reset empties the result register, restores the configuration
// defaults, clears the frame and index, sets clock, ack and select high and
// clears the countdown; the block accepts words from the first cycle after.
module mouse_nibble_handshake_port #(
   parameter int unsigned DELAY_BITS = mnhp_pkg::DELAY_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mnhp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mnhp_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);
   import mnhp_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   logic    take;
   rsp_type rsp;

   // Accept while the result slot is free or draining
   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign take         = req_valid && req_ready;
   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_ready);

   mnhp_core #(
      .DELAY_BITS (DELAY_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .req       (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp       (rsp)
   );

   // Result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp;

endmodule

FILE: rtl/mnhp_frame.sv
module mnhp_frame (
   input  mnhp_pkg::req_type   req,
   input  logic [7:0]          max_speed,
   output mnhp_pkg::frame_type frame
);
   import mnhp_pkg::*;

   logic signed [16:0] x_wide;
   logic signed [16:0] y_wide;
   logic signed [16:0] lim_pos;
   logic signed [16:0] lim_neg;
   logic signed [16:0] x_clamp;
   logic signed [16:0] y_clamp;

   // Widen the samples; negate Y exactly in 17 bits
   assign x_wide  = 17'(req.move_x);
   assign y_wide  = -(17'(req.move_y));
   assign lim_pos = $signed({9'd0, max_speed});
   assign lim_neg = -lim_pos;

   // Clamp each axis to plus or minus the limit
   always_comb begin
      if (x_wide > lim_pos) begin
         x_clamp = lim_pos;
      end else if (x_wide < lim_neg) begin
         x_clamp = lim_neg;
      end else begin
         x_clamp = x_wide;
      end
      if (y_wide > lim_pos) begin
         y_clamp = lim_pos;
      end else if (y_wide < lim_neg) begin
         y_clamp = lim_neg;
      end else begin
         y_clamp = y_wide;
      end
   end

   // Pack the nibbles
   always_comb begin
      frame.sign_nib   = {2'b00, y_clamp[8], x_clamp[8]};
      frame.button_nib = {req.button_start, req.button_middle, req.button_right,
                          req.button_left};
      frame.x_hi       = x_clamp[7:4];
      frame.x_lo       = x_clamp[3:0];
      frame.y_hi       = y_clamp[7:4];
      frame.y_lo       = y_clamp[3:0];
   end

endmodule

FILE: rtl/mnhp_core.sv
`include "mouse_nibble_handshake_port_defines.svh"

module mnhp_core #(
   parameter int unsigned DELAY_BITS = mnhp_pkg::DELAY_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  mnhp_pkg::req_type req,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata,
   output mnhp_pkg::rsp_type rsp
);
   import mnhp_pkg::*;

   localparam int unsigned CmpBits = (DELAY_BITS > 8) ? DELAY_BITS : 8;

   logic [7:0]            max_speed_ff;
   logic [7:0]            hs_delay_ff;
   logic [7:0]            data_delay_ff;
   frame_type             frame_ff, frame_in, frame_new;
   logic [3:0]            idx_ff, idx_in;
   logic                  clk_ff, clk_in;
   logic                  ack_ff, ack_in;
   logic                  sel_ff, sel_in;
   logic [DELAY_BITS-1:0] cnt_ff, cnt_in;
   logic [DELAY_BITS-1:0] cnt_dec;
   logic [DELAY_BITS-1:0] cnt_load;
   logic [CmpBits-1:0]    hs_wide;
   logic                  tick_take;
   logic                  write_take;
   logic [3:0]            nib;
   rsp_type               rsp_ff, rsp_in;

   // Build the frame from the incoming word
   mnhp_frame u_frame (
      .req       (req),
      .max_speed (max_speed_ff),
      .frame     (frame_new)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff  <= MAX_SPEED_RST;
         hs_delay_ff   <= HANDSHAKE_DELAY_RST;
         data_delay_ff <= DATA_DELAY_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_SPEED:       max_speed_ff  <= csr_wdata;
            CSR_HANDSHAKE_DELAY: hs_delay_ff   <= csr_wdata;
            CSR_DATA_DELAY:      data_delay_ff <= csr_wdata;
            default:             ;
         endcase
      end
   end

   assign hs_wide    = CmpBits'(hs_delay_ff);
   assign cnt_load   = hs_wide[DELAY_BITS-1:0];
   assign cnt_dec    = cnt_ff - 1'b1;
   assign tick_take  = take && (req.func == FUNC_TICK);
   assign write_take = take && (req.func == FUNC_WRITE) &&
                       !((req.write_clock == clk_ff) && (req.write_select == sel_ff));

   // Next state for one word
   always_comb begin
      frame_in = frame_ff;
      idx_in   = idx_ff;
      clk_in   = clk_ff;
      ack_in   = ack_ff;
      sel_in   = sel_ff;
      cnt_in   = cnt_ff;
      if (tick_take && (cnt_ff != '0)) begin
         // advance the countdown
         cnt_in = cnt_dec;
         if (CmpBits'(cnt_dec) == CmpBits'(data_delay_ff)) begin
            idx_in = (idx_ff == IDX_LAST) ? IDX_FIRST : idx_ff + 4'd1;
         end
         if (cnt_dec == '0) begin
            ack_in = clk_ff;
         end
      end else if (write_take) begin
         // latch a new frame on select fall
         if (!req.write_select && sel_ff) begin
            frame_in = frame_new;
            idx_in   = IDX_FIRST;
         end
         clk_in = req.write_clock;
         if (req.write_clock != ack_ff) begin
            cnt_in = cnt_load;
         end
         sel_in = req.write_select;
      end
   end

   // Nibble on the data pins after this word
   always_comb begin
      unique case (idx_in)
         4'd0:    nib = HDR_NIB0;
         4'd1:    nib = HDR_NIB1;
         4'd2:    nib = HDR_NIB2;
         4'd3:    nib = HDR_NIB3;
         4'd4:    nib = frame_in.sign_nib;
         4'd5:    nib = frame_in.button_nib;
         4'd6:    nib = frame_in.x_hi;
         4'd7:    nib = frame_in.x_lo;
         4'd8:    nib = frame_in.y_hi;
         4'd9:    nib = frame_in.y_lo;
         default: nib = 4'h0;
      endcase
      rsp_in.port_nibble = sel_in ? 4'h0 : nib;
      rsp_in.ack_level   = ack_in;
   end

   // Port state
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         idx_ff   <= 4'd0;
         clk_ff   <= 1'b1;
         ack_ff   <= 1'b1;
         sel_ff   <= 1'b1;
         cnt_ff   <= '0;
      end else begin
         frame_ff <= frame_in;
         idx_ff   <= idx_in;
         clk_ff   <= clk_in;
         ack_ff   <= ack_in;
         sel_ff   <= sel_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Result payload, loaded with each accepted word
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

   `MNHP_ASSERT_ALWAYS(a_idx_range, idx_ff <= IDX_LAST, "nibble index beyond frame end")
   `MNHP_ASSERT_ALWAYS(a_ack_on_tick, $stable(ack_ff) || $past(tick_take), "ack moved without a tick")
   `MNHP_ASSERT_IMPLY(a_idx_on_write, (idx_ff == IDX_FIRST) && !$stable(idx_ff), $past(take), "index moved without a word")
   `MNHP_ASSERT_IMPLY(a_rsp_ack, $past(take), rsp_ff.ack_level == ack_ff, "result ack differs from ack line")

endmodule
